>>> design/leb_pkg.sv
// shared types and constants for the line edit buffer
package leb_pkg;

  localparam int LINE_DEPTH_DEF = 64;

  localparam logic [7:0] ERASE_RST = 8'd8;
  localparam logic [7:0] KILL_RST  = 8'd21;
  localparam logic [7:0] WERASE_RST = 8'd23;
  localparam logic [6:0] LIMIT_RST = 7'd64;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;

  typedef enum logic [2:0] {
    KIND_ECHO      = 3'd0,
    KIND_RUB       = 3'd1,
    KIND_BELL      = 3'd2,
    KIND_LINE_CHAR = 3'd3,
    KIND_LINE_END  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    REG_ERASE  = 2'd0,
    REG_KILL   = 2'd1,
    REG_WERASE = 2'd2,
    REG_LIMIT  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] erase_char;
    logic [7:0] kill_char;
    logic [7:0] word_erase_char;
    logic [6:0] line_limit;
  } cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] char_value;
    logic [5:0] line_length;
    logic       last;
  } res_t;

endpackage

>>> design/leb_store.sv
// line store: one write port, one registered read port
module leb_store import leb_pkg::*; #(
  parameter int DEPTH = LINE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/leb_seq.sv
// command sequencer: decode, fill count and the walk over the line store
module leb_seq import leb_pkg::*; #(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF,
  parameter int PTR_W      = $clog2(LINE_DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [7:0]       in_char,
  input  cfg_t             cfg,
  output logic             busy,
  output logic             res_valid,
  output res_t             res,
  output logic             wr_en,
  output logic [PTR_W-1:0] wr_addr,
  output logic [7:0]       wr_data,
  output logic             rd_en,
  output logic [PTR_W-1:0] rd_addr,
  input  logic [7:0]       rd_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUB  = 4'b0010,
    S_LINE = 4'b0100,
    S_END  = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    MODE_ERASE = 2'd0,
    MODE_KILL  = 2'd1,
    MODE_WORD  = 2'd2
  } mode_t;

  state_t           state, state_next;
  mode_t            mode, mode_next;
  logic [PTR_W-1:0] fill, fill_next;
  logic [PTR_W-1:0] idx, idx_next;
  logic             phase_word, phase_word_next;
  logic             pend_valid, pend_valid_next;
  logic [7:0]       pend_char, pend_char_next;

  logic [PTR_W-1:0] cap;
  logic             is_erase, is_kill, is_word, is_eol;
  logic             data_blank, stop;

  // storable count: min(limit, depth) - 1, a zero limit acting as one
  always_comb begin
    if (cfg.line_limit == 7'd0) begin
      cap = '0;
    end else if (cfg.line_limit > 7'(LINE_DEPTH)) begin
      cap = PTR_W'(LINE_DEPTH - 1);
    end else begin
      cap = PTR_W'(cfg.line_limit - 7'd1);
    end
  end

  assign is_erase   = (in_char == cfg.erase_char);
  assign is_kill    = (in_char == cfg.kill_char);
  assign is_word    = (in_char == cfg.word_erase_char);
  assign is_eol     = (in_char == CHAR_CR) || (in_char == CHAR_LF);
  assign data_blank = (rd_data == CHAR_SPACE) || (rd_data == CHAR_TAB);

  // end of a rub run; the held rub goes out with last set
  assign stop = (fill == '0) ||
                ((mode == MODE_ERASE) && pend_valid) ||
                ((mode == MODE_WORD) && phase_word && data_blank);

  assign busy    = (state != S_IDLE);
  assign wr_addr = fill;
  assign wr_data = in_char;

  always_comb begin
    state_next      = state;
    mode_next       = mode;
    fill_next       = fill;
    idx_next        = idx;
    phase_word_next = phase_word;
    pend_valid_next = pend_valid;
    pend_char_next  = pend_char;
    res_valid       = 1'b0;
    res             = '{kind: KIND_ECHO, char_value: 8'd0, line_length: 6'd0, last: 1'b0};
    wr_en           = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = fill - PTR_W'(1);
    unique case (state)
      S_IDLE: begin
        if (start) begin
          priority if (is_erase || is_kill || is_word) begin
            priority if (is_erase) begin
              mode_next = MODE_ERASE;
            end else if (is_kill) begin
              mode_next = MODE_KILL;
            end else begin
              mode_next = MODE_WORD;
            end
            phase_word_next = 1'b0;
            pend_valid_next = 1'b0;
            rd_en           = (fill != '0);
            state_next      = S_RUB;
          end else if (is_eol) begin
            idx_next = '0;
            rd_addr  = '0;
            if (fill != '0) begin
              rd_en      = 1'b1;
              state_next = S_LINE;
            end else begin
              state_next = S_END;
            end
          end else if (fill >= cap) begin
            res_valid = 1'b1;
            res.kind  = KIND_BELL;
            res.last  = 1'b1;
          end else begin
            wr_en          = 1'b1;
            fill_next      = fill + PTR_W'(1);
            res_valid      = 1'b1;
            res.kind       = KIND_ECHO;
            res.char_value = in_char;
            res.last       = 1'b1;
          end
        end
      end
      S_RUB: begin
        // rd_data holds the entry at fill-1
        res_valid      = pend_valid;
        res.kind       = KIND_RUB;
        res.char_value = pend_char;
        res.last       = stop;
        rd_addr        = fill - PTR_W'(2);
        if (stop) begin
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end else begin
          pend_valid_next = 1'b1;
          pend_char_next  = rd_data;
          fill_next       = fill - PTR_W'(1);
          rd_en           = (fill != PTR_W'(1));
          if (!data_blank) begin
            phase_word_next = 1'b1;
          end
        end
      end
      S_LINE: begin
        // rd_data holds the entry at idx
        res_valid      = 1'b1;
        res.kind       = KIND_LINE_CHAR;
        res.char_value = rd_data;
        if (idx == fill - PTR_W'(1)) begin
          state_next = S_END;
        end else begin
          idx_next = idx + PTR_W'(1);
          rd_addr  = idx + PTR_W'(1);
          rd_en    = 1'b1;
        end
      end
      S_END: begin
        res_valid       = 1'b1;
        res.kind        = KIND_LINE_END;
        res.line_length = 6'(fill);
        res.last        = 1'b1;
        fill_next       = '0;
        state_next      = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill       <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      fill       <= fill_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    mode       <= mode_next;
    idx        <= idx_next;
    phase_word <= phase_word_next;
    pend_char  <= pend_char_next;
  end

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) && !start |-> !res_valid)
    else $error("result produced with no command");

  a_echo_grows: assert property (@(posedge clk) disable iff (rst)
    !rst && res_valid && (res.kind == KIND_ECHO) |=> fill == $past(fill) + PTR_W'(1))
    else $error("echo did not grow the line by one");

  a_end_empties: assert property (@(posedge clk) disable iff (rst)
    !rst && res_valid && (res.kind == KIND_LINE_END) |=> (fill == '0) && (state == S_IDLE))
    else $error("line end did not empty the line");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.kind == KIND_LINE_END) |-> res.last)
    else $error("line end not marked last");

  a_rub_shrinks: assert property (@(posedge clk) disable iff (rst)
    !rst && (state == S_RUB) && !stop |=> fill == $past(fill) - PTR_W'(1))
    else $error("rub step did not shrink the line");

endmodule

>>> design/line_edit_buffer.sv
// top level of the line edit buffer: config registers, sequencer, store, result register
//
// One typed character is taken per command transfer (start high while busy is low).
// An ordinary character is stored and echoed, or rings the bell when the line is full;
// busy stays low and the next character may follow at once. Erase, kill and word erase
// walk the stored line backward through the one read port of the line store, one entry
// per cycle, with busy high until the walk stops. CR or LF walks the line forward the
// same way, giving each stored character in order, then the line end. Results leave
// through a registered stage, in the cycle after they are formed, each on the result
// ports for exactly one cycle while strobe is high; the receiver takes every result and
// cannot hold the block off. The final result of a character carries last. Config
// registers may be written only while the block is idle and its last
// result has gone out.
module line_edit_buffer import leb_pkg::*; #(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // command channel
  input  logic       start,
  input  logic [7:0] in_char,
  output logic       busy,
  // config write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  // result channel
  output logic       strobe,
  output logic [2:0] kind,
  output logic [7:0] char_value,
  output logic [5:0] line_length,
  output logic       last
);

  localparam int PTR_W = $clog2(LINE_DEPTH);

  cfg_t             cfg;
  logic             res_valid;
  res_t             res;
  res_t             res_q;
  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;
  logic [7:0]       wr_data;
  logic             rd_en;
  logic [PTR_W-1:0] rd_addr;
  logic [7:0]       rd_data;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.erase_char      <= ERASE_RST;
      cfg.kill_char       <= KILL_RST;
      cfg.word_erase_char <= WERASE_RST;
      cfg.line_limit      <= LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ERASE:  cfg.erase_char      <= cfg_data;
        REG_KILL:   cfg.kill_char       <= cfg_data;
        REG_WERASE: cfg.word_erase_char <= cfg_data;
        REG_LIMIT:  cfg.line_limit      <= cfg_data[6:0];
        default:    cfg.line_limit      <= cfg.line_limit;
      endcase
    end
  end

  // decode and walk control
  leb_seq #(
    .LINE_DEPTH (LINE_DEPTH),
    .PTR_W      (PTR_W)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .in_char   (in_char),
    .cfg       (cfg),
    .busy      (busy),
    .res_valid (res_valid),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  // stored characters of the current line
  leb_store #(
    .DEPTH (LINE_DEPTH),
    .AW    (PTR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // result register: one transfer per strobe cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign kind        = res_q.kind;
  assign char_value  = res_q.char_value;
  assign line_length = res_q.line_length;
  assign last        = res_q.last;

endmodule
